FILE: rtl/core/sha_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and round functions for the SHA-256 compression unit.
package sha_pkg;

  localparam int HashWords  = 8;
  localparam int BlockWords = 16;
  localparam int Rounds     = 64;
  localparam int QueueDepth = 4;

  localparam logic [31:0] INIT_HASH [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic        first_blk;
    logic        final_blk;
  } word_entry_t;

  typedef struct packed {
    logic        valid;
    word_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: rtl/core/sha_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message words and digest words.
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        first_block;
  logic        final_block;

  modport source (output valid, message_word, first_block, final_block, input ready);
  modport sink   (input valid, message_word, first_block, final_block, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  modport source (output valid, digest_word, word_number, last_word, input ready);
  modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

FILE: rtl/core/sha_front.sv
`timescale 1ns / 1ps
// Input front end: counts words within a block and tags block-level flags.
module sha_front (
  input  logic                clk,
  input  logic                rst_n,
  sha_in_if.sink              in_chan,
  input  sha_pkg::q_status_t  q_status,
  output sha_pkg::q_push_t    q_push
);

  logic [3:0] word_count_r;
  logic [3:0] word_count_nxt;
  logic       accept;

  assign in_chan.ready = !q_status.full;
  assign accept        = in_chan.valid && in_chan.ready;

  // first_block counts on word 0 only, final_block on word 15 only
  always_comb begin
    q_push.valid           = accept;
    q_push.entry.word      = in_chan.message_word;
    q_push.entry.first_blk = in_chan.first_block && (word_count_r == 4'd0);
    q_push.entry.final_blk = in_chan.final_block && (word_count_r == 4'd15);
    word_count_nxt         = accept ? word_count_r + 4'd1 : word_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= 4'd0;
    end else begin
      word_count_r <= word_count_nxt;
    end
  end

endmodule

FILE: rtl/core/sha_queue.sv
`timescale 1ns / 1ps
// Small first-word-fall-through queue between the front end and the round engine.
module sha_queue #(
  parameter int Depth = sha_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha_pkg::q_push_t     q_push,
  output sha_pkg::q_status_t   q_status,
  input  logic                 q_pop,
  output sha_pkg::word_entry_t q_head
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sha_pkg::word_entry_t mem_r [Depth];
  logic [IdxW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IdxW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push_ok;
  logic            pop_ok;

  assign q_status.full  = (count_r == CntW'(Depth));
  assign q_status.empty = (count_r == '0);
  assign push_ok        = q_push.valid && !q_status.full;
  assign pop_ok         = q_pop && !q_status.empty;
  assign q_head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == IdxW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == IdxW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("queue occupancy above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

FILE: rtl/core/sha_back.sv
`timescale 1ns / 1ps
// Round engine: message schedule, 64 rounds, hash update and digest readout.
module sha_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha_pkg::word_entry_t q_head,
  input  sha_pkg::q_status_t   q_status,
  output logic                 q_pop,
  sha_out_if.source            out_chan
);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_RUN  = 4'b0010,
    S_ADD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        final_r, final_nxt;
  logic [31:0] hash_r  [sha_pkg::HashWords];
  logic [31:0] v_r     [sha_pkg::HashWords];
  logic [31:0] w_r     [sha_pkg::BlockWords];
  logic [31:0] wk_r;
  logic [31:0] wt;
  logic [31:0] t1;
  logic [31:0] t2;
  logic        in_msg;
  logic        step;
  logic        do_sched;
  logic        do_round;
  logic        load_go;

  assign in_msg   = (cnt_r < 7'd16);
  assign step     = (state_r == S_RUN) && (!in_msg || !q_status.empty);
  assign do_sched = step && (cnt_r < 7'd64);
  assign do_round = step && (cnt_r != 7'd0);
  assign q_pop    = step && in_msg;
  assign load_go  = (state_r == S_LOAD) && !q_status.empty;

  assign wt = in_msg ? q_head.word
                     : w_r[0] + sha_pkg::small_sigma0(w_r[1]) + w_r[9]
                       + sha_pkg::small_sigma1(w_r[14]);

  assign t1 = v_r[7] + sha_pkg::big_sigma1(v_r[4])
              + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + wk_r;
  assign t2 = sha_pkg::big_sigma0(v_r[0])
              + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    final_nxt = final_r;
    unique case (state_r)
      S_LOAD: begin
        if (load_go) begin
          cnt_nxt   = 7'd0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (step) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd15) begin
            final_nxt = q_head.final_blk;
          end
          if (cnt_r == 7'd64) begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        idx_nxt   = 3'd0;
        state_nxt = final_r ? S_OUT : S_LOAD;
      end
      S_OUT: begin
        if (out_chan.ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= 7'd0;
      idx_r   <= 3'd0;
      final_r <= 1'b0;
      for (int k = 0; k < sha_pkg::HashWords; k++) begin
        hash_r[k] <= sha_pkg::INIT_HASH[k];
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      final_r <= final_nxt;
      if (load_go && q_head.first_blk) begin
        for (int k = 0; k < sha_pkg::HashWords; k++) begin
          hash_r[k] <= sha_pkg::INIT_HASH[k];
        end
      end else if (state_r == S_ADD) begin
        for (int k = 0; k < sha_pkg::HashWords; k++) begin
          hash_r[k] <= hash_r[k] + v_r[k];
        end
      end
    end
  end

  // schedule runs one step ahead of the rounds; wk_r carries W[t] + K[t]
  always_ff @(posedge clk) begin
    if (do_sched) begin
      for (int k = 0; k < sha_pkg::BlockWords - 1; k++) begin
        w_r[k] <= w_r[k+1];
      end
      w_r[sha_pkg::BlockWords-1] <= wt;
      wk_r <= wt + sha_pkg::ROUND_K[cnt_r[5:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      for (int k = 0; k < sha_pkg::HashWords; k++) begin
        v_r[k] <= q_head.first_blk ? sha_pkg::INIT_HASH[k] : hash_r[k];
      end
    end else if (do_round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign out_chan.valid       = (state_r == S_OUT);
  assign out_chan.digest_word = hash_r[idx_r];
  assign out_chan.word_number = idx_r;
  assign out_chan.last_word   = (idx_r == 3'd7);

  a_pop_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ((state_r == S_RUN) && (cnt_r < 7'd16)))
    else $error("queue popped outside message load");

  a_final_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ADD) && final_r) |=> ((state_r == S_OUT) && (idx_r == 3'd0)))
    else $error("final block did not start digest readout");

  a_hash_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && $past(state_r == S_OUT)) |-> $stable(hash_r[0]))
    else $error("chaining hash changed during readout");

endmodule

FILE: rtl/core/sha256_block_compression_unit.sv
`timescale 1ns / 1ps
// Top level of the SHA-256 block compression unit.
//
//   channel   | dir | payload                                   | transaction
//   in_chan   | in  | message_word, first_block, final_block    | one message word
//   out_chan  | out | digest_word, word_number, last_word       | one digest word
//
// In the round engine a block takes one load, 65 schedule/round steps (one
// round per cycle while not waiting on the queue, schedule one step ahead) and
// one hash add; a final block adds 8 readout beats.
// Reset loads the initial hash values and empties the word queue.
// Words are taken while the queue has room; the engine waits on an empty queue
// during the first 16 steps; digest words hold until out_chan.ready.
module sha256_block_compression_unit #(
  parameter int QueueDepth = sha_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  sha_in_if.sink    in_chan,
  sha_out_if.source out_chan
);

  sha_pkg::q_push_t     q_push;
  sha_pkg::q_status_t   q_status;
  sha_pkg::word_entry_t q_head;
  logic                 q_pop;

  sha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_status (q_status),
    .q_push   (q_push)
  );

  sha_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_status (q_status),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  sha_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_status (q_status),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
